@@ rtl/core/pbpb_pkg.sv @@
package pbpb_pkg;

    // Powder layer depth, Q16.16
    localparam longint POWDER_DEPTH_Q16 = 65536;

    // 1.0 in Q0.16 and Q16.16
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Layer test: 1000 * z + 1001 * depth > 0 (exact form of z > -1.001 * depth)
    localparam logic signed [42:0] LAYER_OFFSET = 43'(longint'(1001) * POWDER_DEPTH_Q16);
    localparam logic signed [42:0] LAYER_GAIN   = 43'sd1000;

    // Saturation bounds of the 32-bit result, held at the width of the wide sum
    localparam logic signed [49:0] PROP_MAX = 50'sh0_0000_7FFF_FFFF;
    localparam logic signed [49:0] PROP_MIN = -50'sh0_0000_8000_0000;

    // Pipeline shape
    localparam int N_STAGES   = 21;
    localparam int DIV_STEPS  = 16;
    localparam int IN_BITS    = 120;
    localparam int OUT_BITS   = 56;

    typedef enum logic [2:0] {
        REG_SOLID_BASE  = 3'd0,
        REG_SOLID_GAIN  = 3'd1,
        REG_LIQUID_BASE = 3'd2,
        REG_LIQUID_GAIN = 3'd3,
        REG_POWDER_BASE = 3'd4,
        REG_POWDER_GAIN = 3'd5,
        REG_SOLIDUS     = 3'd6,
        REG_LIQUIDUS    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        q_bit;
        logic [31:0] rem;
    } div_step_t;

    // One restoring division step: shift the partial remainder, subtract if it fits.
    function automatic div_step_t div_step(input logic [31:0] rem, input logic [31:0] den);
        logic [32:0] shifted;
        logic [32:0] diff;
        div_step_t   res;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, den};
        if (shifted >= {1'b0, den})
        begin
            res.q_bit = 1'b1;
            res.rem   = diff[31:0];
        end
        else
        begin
            res.q_bit = 1'b0;
            res.rem   = shifted[31:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/powder_bed_property_blend.sv @@
// Powder bed property blend. Each s_axis transfer carries one mesh node; each m_axis
// transfer returns its blended Q16.16 property, saturated to 32 bits, and the
// consolidation factor alpha in Q0.16. Results leave in input order. The block takes
// one node per clock while m_axis_tready stays high. Alpha comes from a restoring divider
// that resolves one quotient bit per pipeline stage over 16 stages. Every stage holds its
// item under backpressure and a bubble in front of a stalled stage is still filled, so
// the input keeps taking nodes until all 21 stages hold data. Write the eight configuration
// registers only while no node is in flight; the pipeline reads them directly.
module powder_bed_property_blend
    import pbpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // node_temp[31:0], peak_temp[63:32], melt_fraction[80:64], height[112:81], zero pad
    input  logic [IN_BITS-1:0]    s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // property_value[31:0], consolidated_fraction[48:32], zero pad
    output logic [OUT_BITS-1:0]   m_axis_tdata,

    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_wdata
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic signed [31:0] solid_base_reg;
    logic signed [31:0] solid_gain_reg;
    logic signed [31:0] liquid_base_reg;
    logic signed [31:0] liquid_gain_reg;
    logic signed [31:0] powder_base_reg;
    logic signed [31:0] powder_gain_reg;
    logic signed [31:0] solidus_reg;
    logic signed [31:0] liquidus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solid_base_reg  <= '0;
            solid_gain_reg  <= '0;
            liquid_base_reg <= '0;
            liquid_gain_reg <= '0;
            powder_base_reg <= '0;
            powder_gain_reg <= '0;
            solidus_reg     <= '0;
            liquidus_reg    <= 32'(ONE_Q16);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SOLID_BASE:  solid_base_reg  <= cfg_wdata;
                REG_SOLID_GAIN:  solid_gain_reg  <= cfg_wdata;
                REG_LIQUID_BASE: liquid_base_reg <= cfg_wdata;
                REG_LIQUID_GAIN: liquid_gain_reg <= cfg_wdata;
                REG_POWDER_BASE: powder_base_reg <= cfg_wdata;
                REG_POWDER_GAIN: powder_gain_reg <= cfg_wdata;
                REG_SOLIDUS:     solidus_reg     <= cfg_wdata;
                REG_LIQUIDUS:    liquidus_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage flow control: a stage advances when it is empty or the stage
    // behind it advances. Written in closed form so each bit is independent.
    // ---------------------------------------------------------------------
    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] adv;

    always_comb
    begin
        for (int i = 0; i < N_STAGES; i++)
        begin
            // stage i is blocked only if it and every later stage hold data
            adv[i] = m_axis_tready ||
                     !(&(valid_reg | N_STAGES'((N_STAGES'(1) << i) - N_STAGES'(1))));
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < N_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: unpack, three law products, alpha case decode, divider setup
    // ---------------------------------------------------------------------
    logic signed [31:0] in_temp;
    logic signed [31:0] in_peak;
    logic        [16:0] in_frac;
    logic signed [31:0] in_height;
    logic signed [42:0] layer_sum;
    logic               in_layer;
    logic signed [32:0] div_num;
    logic signed [32:0] div_den;
    logic               is_ratio;
    logic               is_one;

    assign in_temp   = s_axis_tdata[31:0];
    assign in_peak   = s_axis_tdata[63:32];
    assign in_frac   = s_axis_tdata[80:64];
    assign in_height = s_axis_tdata[112:81];

    assign layer_sum = 43'(in_height) * LAYER_GAIN + LAYER_OFFSET;
    assign in_layer  = (layer_sum > 43'sd0);
    assign div_num   = 33'(in_peak) - 33'(solidus_reg);
    assign div_den   = 33'(liquidus_reg) - 33'(solidus_reg);
    assign is_ratio  = (in_peak > solidus_reg) && (in_peak < liquidus_reg) && in_layer;
    // full consolidation unless a cold node sits in the powder layer
    assign is_one    = (in_peak >= liquidus_reg) || !(in_layer && (in_peak <= solidus_reg));

    logic signed [63:0] prod_s0_reg;
    logic signed [63:0] prod_l0_reg;
    logic signed [63:0] prod_p0_reg;
    logic        [16:0] frac0_reg;

    // divider pipeline, indexed by stage
    logic [31:0] rem_reg   [0:DIV_STEPS];
    logic [31:0] den_reg   [0:DIV_STEPS];
    logic [15:0] quot_reg  [0:DIV_STEPS];
    logic        ratio_reg [0:DIV_STEPS];
    logic        one_reg   [0:DIV_STEPS];
    div_step_t   step_res  [1:DIV_STEPS];

    always_comb
    begin
        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            step_res[i] = div_step(rem_reg[i-1], den_reg[i-1]);
        end
    end

    // ---------------------------------------------------------------------
    // Property path registers
    // ---------------------------------------------------------------------
    logic signed [48:0] solid1_reg,  liquid1_reg, powder1_reg;
    logic        [16:0] frac1_reg;
    logic signed [48:0] solid2_reg,  powder2_reg;
    logic signed [49:0] dsl2_reg;
    logic        [16:0] frac2_reg;
    logic signed [48:0] solid3_reg,  powder3_reg;
    logic signed [42:0] pp_hi3_reg;
    logic        [41:0] pp_lo3_reg;
    logic signed [48:0] solid4_reg,  powder4_reg;
    logic signed [67:0] mix4_reg;
    logic signed [49:0] bulk5_reg;
    logic signed [48:0] powder5_reg;
    logic signed [50:0] dbp_reg    [6:16];
    logic signed [48:0] powder_reg [6:16];
    logic signed [42:0] pp_hi17_reg;
    logic        [42:0] pp_lo17_reg;
    logic signed [48:0] powder17_reg;
    logic        [16:0] alpha17_reg;
    logic signed [68:0] mix18_reg;
    logic signed [48:0] powder18_reg;
    logic        [16:0] alpha18_reg;
    logic signed [49:0] prop19_reg;
    logic        [16:0] alpha19_reg;
    logic signed [31:0] prop_out_reg;
    logic        [16:0] alpha_out_reg;

    // split factors of the two wide products
    logic signed [24:0] dsl_hi;
    logic        [24:0] dsl_lo;
    logic signed [24:0] dbp_hi;
    logic        [25:0] dbp_lo;
    logic        [16:0] alpha_sel;

    assign dsl_hi    = dsl2_reg[49:25];
    assign dsl_lo    = dsl2_reg[24:0];
    assign dbp_hi    = dbp_reg[16][50:26];
    assign dbp_lo    = dbp_reg[16][25:0];
    assign alpha_sel = ratio_reg[DIV_STEPS] ? {1'b0, quot_reg[DIV_STEPS]} :
                       (one_reg[DIV_STEPS] ? ONE_Q16 : 17'd0);

    always_ff @(posedge clk)
    begin
        // stage 0
        if (adv[0])
        begin
            prod_s0_reg  <= 64'(solid_gain_reg)  * 64'(in_temp);
            prod_l0_reg  <= 64'(liquid_gain_reg) * 64'(in_temp);
            prod_p0_reg  <= 64'(powder_gain_reg) * 64'(in_temp);
            frac0_reg    <= (in_frac > ONE_Q16) ? ONE_Q16 : in_frac;
            rem_reg[0]   <= div_num[31:0];
            den_reg[0]   <= div_den[31:0];
            quot_reg[0]  <= '0;
            ratio_reg[0] <= is_ratio;
            one_reg[0]   <= is_one;
        end

        // divider: one quotient bit per stage
        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            if (adv[i])
            begin
                rem_reg[i]   <= step_res[i].rem;
                den_reg[i]   <= den_reg[i-1];
                quot_reg[i]  <= {quot_reg[i-1][14:0], step_res[i].q_bit};
                ratio_reg[i] <= ratio_reg[i-1];
                one_reg[i]   <= one_reg[i-1];
            end
        end

        // stage 1: evaluate the three laws
        if (adv[1])
        begin
            solid1_reg  <= 49'(solid_base_reg)  + 49'(prod_s0_reg >>> 16);
            liquid1_reg <= 49'(liquid_base_reg) + 49'(prod_l0_reg >>> 16);
            powder1_reg <= 49'(powder_base_reg) + 49'(prod_p0_reg >>> 16);
            frac1_reg   <= frac0_reg;
        end

        // stage 2: liquid minus solid
        if (adv[2])
        begin
            solid2_reg  <= solid1_reg;
            powder2_reg <= powder1_reg;
            dsl2_reg    <= 50'(liquid1_reg) - 50'(solid1_reg);
            frac2_reg   <= frac1_reg;
        end

        // stage 3: fraction times difference, two partial products
        if (adv[3])
        begin
            solid3_reg  <= solid2_reg;
            powder3_reg <= powder2_reg;
            pp_hi3_reg  <= 43'(dsl_hi) * 43'($signed({1'b0, frac2_reg}));
            pp_lo3_reg  <= 42'(frac2_reg) * 42'(dsl_lo);
        end

        // stage 4: join partial products
        if (adv[4])
        begin
            solid4_reg  <= solid3_reg;
            powder4_reg <= powder3_reg;
            mix4_reg    <= (68'(pp_hi3_reg) <<< 25) + $signed({26'd0, pp_lo3_reg});
        end

        // stage 5: bulk = solid + floor(f * (liquid - solid) / 2^16)
        if (adv[5])
        begin
            bulk5_reg   <= 50'(solid4_reg) + 50'(mix4_reg >>> 16);
            powder5_reg <= powder4_reg;
        end

        // stage 6: bulk minus powder, then hold until alpha is ready
        if (adv[6])
        begin
            dbp_reg[6]    <= 51'(bulk5_reg) - 51'(powder5_reg);
            powder_reg[6] <= powder5_reg;
        end
        for (int i = 7; i <= 16; i++)
        begin
            if (adv[i])
            begin
                dbp_reg[i]    <= dbp_reg[i-1];
                powder_reg[i] <= powder_reg[i-1];
            end
        end

        // stage 17: select alpha, alpha times difference in two parts
        if (adv[17])
        begin
            pp_hi17_reg  <= 43'(dbp_hi) * 43'($signed({1'b0, alpha_sel}));
            pp_lo17_reg  <= 43'(alpha_sel) * 43'(dbp_lo);
            powder17_reg <= powder_reg[16];
            alpha17_reg  <= alpha_sel;
        end

        // stage 18: join partial products
        if (adv[18])
        begin
            mix18_reg    <= (69'(pp_hi17_reg) <<< 26) + $signed({26'd0, pp_lo17_reg});
            powder18_reg <= powder17_reg;
            alpha18_reg  <= alpha17_reg;
        end

        // stage 19: property = powder + floor(alpha * (bulk - powder) / 2^16)
        if (adv[19])
        begin
            prop19_reg  <= 50'(powder18_reg) + 50'(mix18_reg >>> 16);
            alpha19_reg <= alpha18_reg;
        end

        // stage 20: saturate into the output register
        if (adv[20])
        begin
            if (prop19_reg > PROP_MAX)
            begin
                prop_out_reg <= PROP_MAX[31:0];
            end
            else if (prop19_reg < PROP_MIN)
            begin
                prop_out_reg <= PROP_MIN[31:0];
            end
            else
            begin
                prop_out_reg <= prop19_reg[31:0];
            end
            alpha_out_reg <= alpha19_reg;
        end
    end

    assign m_axis_tdata = {7'd0, alpha_out_reg, prop_out_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // input is refused only when every stage is occupied
    a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg))
        else $error("input refused while a pipeline stage is empty");

    // an output transfer frees the whole chain
    a_drain_opens_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
        else $error("input stalled during an output transfer");

    // alpha never exceeds one
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (alpha_out_reg <= ONE_Q16))
        else $error("consolidated fraction above one");

endmodule
